// ===== hw/rtl/ppm_pkg.sv =====
// Shared types, constants and register codes of the pulse parameter measurement block.
package ppm_pkg;

  localparam int unsigned SAMPLE_W        = 16;
  localparam int unsigned FRAC_W          = 16;
  localparam int unsigned COUNT_W         = 13;
  localparam int unsigned INDEX_W         = 12;
  localparam int unsigned CFG_INDEX_W     = 8;
  localparam int unsigned CFG_DATA_W      = 16;
  localparam int unsigned MAX_SAMPLES_DEF = 4096;

  // Thresholds are compared at full precision: sample * 2^FRAC_W against
  // min * 2^FRAC_W + frac * swing, which needs one bit of headroom.
  localparam int unsigned THR_W = SAMPLE_W + FRAC_W + 1;

  localparam logic [FRAC_W-1:0]   PULSE_FRAC_RST   = 16'd32768;
  localparam logic [FRAC_W-1:0]   EDGE_LOW_RST     = 16'd6554;
  localparam logic [FRAC_W-1:0]   EDGE_HIGH_RST    = 16'd58982;
  localparam logic [SAMPLE_W-1:0] TARGET_LEVEL_RST = 16'd0;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PULSE_FRAC   = 8'd0,
    REG_EDGE_LOW     = 8'd1,
    REG_EDGE_HIGH    = 8'd2,
    REG_TARGET_LEVEL = 8'd3
  } ppm_reg_e;

  typedef enum logic [1:0] {
    THR_PULSE,
    THR_LOW,
    THR_HIGH
  } ppm_thr_e;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_THR_PULSE,
    ST_THR_LOW,
    ST_THR_HIGH,
    ST_PASS,
    ST_DRAIN,
    ST_DONE
  } ppm_state_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                       frame_last;
  } ppm_sample_t;

  typedef struct packed {
    logic        [COUNT_W-1:0]  pulse_width_count;
    logic        [COUNT_W-1:0]  rise_count;
    logic        [COUNT_W-1:0]  fall_count;
    logic                       level_found;
    logic        [INDEX_W-1:0]  level_cross_index;
    logic        [INDEX_W-1:0]  peak_index;
    logic signed [SAMPLE_W-1:0] min_value;
    logic signed [SAMPLE_W-1:0] max_value;
  } ppm_result_t;

  typedef struct packed {
    logic        [FRAC_W-1:0]   pulse_frac;
    logic        [FRAC_W-1:0]   edge_low_frac;
    logic        [FRAC_W-1:0]   edge_high_frac;
    logic signed [SAMPLE_W-1:0] target_level;
  } ppm_cfg_t;

  typedef struct packed {
    logic     load;       // take one sample into the store and the trackers
    logic     thr_en;     // compute one threshold
    ppm_thr_e thr_sel;
    logic     pass_init;  // clear pass counters and the read address
    logic     rd_en;      // read one stored sample
    logic     finish;     // clear frame state after the result
  } ppm_cmd_t;

  typedef struct packed {
    logic rd_last;
  } ppm_status_t;

endpackage

// ===== hw/rtl/pulse_parameter_measurement.sv =====
// Top level of the pulse parameter measurement block.
// Samples are taken one per cycle while busy is low; the item marked as the
// last of a frame makes the block busy while, in order, the pulse, low and
// high levels are formed on one shared multiplier, the stored samples (at
// most MAX_SAMPLES) stream out of the single read port of the sample store,
// the final read is evaluated, and in the last busy cycle done_o pulses with
// the result. The result is on result_o for that one cycle only and cannot
// be held off by the receiver. Frames longer than MAX_SAMPLES keep their
// first MAX_SAMPLES samples. Configuration writes are always ready and are
// meant for idle time.
module pulse_parameter_measurement
  import ppm_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  ppm_sample_t            sample_i,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output logic                   done_o,
  output ppm_result_t            result_o
);

  ppm_cfg_t    cfg;
  ppm_cmd_t    cmd;
  ppm_status_t status;

  ppm_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ppm_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .frame_last_i (sample_i.frame_last),
    .status_i     (status),
    .cmd_o        (cmd),
    .busy_o       (busy),
    .done_o       (done_o)
  );

  ppm_dp #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_i),
    .cfg_i    (cfg),
    .cmd_i    (cmd),
    .status_o (status),
    .result_o (result_o)
  );

endmodule

// ===== hw/rtl/ppm_regs.sv =====
// Configuration registers of the pulse parameter measurement block.
module ppm_regs
  import ppm_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output ppm_cfg_t               cfg_o
);

  ppm_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_PULSE_FRAC:   cfg_d.pulse_frac     = cfg_data_i;
        REG_EDGE_LOW:     cfg_d.edge_low_frac  = cfg_data_i;
        REG_EDGE_HIGH:    cfg_d.edge_high_frac = cfg_data_i;
        REG_TARGET_LEVEL: cfg_d.target_level   = $signed(cfg_data_i);
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulse_frac     <= PULSE_FRAC_RST;
      cfg_q.edge_low_frac  <= EDGE_LOW_RST;
      cfg_q.edge_high_frac <= EDGE_HIGH_RST;
      cfg_q.target_level   <= $signed(TARGET_LEVEL_RST);
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== hw/rtl/ppm_ctrl.sv =====
// Controller state machine that sequences loading, threshold setup and the counting pass.
module ppm_ctrl
  import ppm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        frame_last_i,
  input  ppm_status_t status_i,
  output ppm_cmd_t    cmd_o,
  output logic        busy_o,
  output logic        done_o
);

  ppm_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.thr_sel = THR_PULSE;
    busy_o        = 1'b1;
    done_o        = 1'b0;
    case (state_q)
      ST_LOAD: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
        if (start_i && frame_last_i) begin
          state_d = ST_THR_PULSE;
        end
      end
      ST_THR_PULSE: begin
        cmd_o.thr_en  = 1'b1;
        cmd_o.thr_sel = THR_PULSE;
        state_d       = ST_THR_LOW;
      end
      ST_THR_LOW: begin
        cmd_o.thr_en  = 1'b1;
        cmd_o.thr_sel = THR_LOW;
        state_d       = ST_THR_HIGH;
      end
      ST_THR_HIGH: begin
        cmd_o.thr_en    = 1'b1;
        cmd_o.thr_sel   = THR_HIGH;
        cmd_o.pass_init = 1'b1;
        state_d         = ST_PASS;
      end
      ST_PASS: begin
        cmd_o.rd_en = 1'b1;
        if (status_i.rd_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // The last read item is evaluated in this cycle.
        state_d = ST_DONE;
      end
      ST_DONE: begin
        done_o       = 1'b1;
        cmd_o.finish = 1'b1;
        state_d      = ST_LOAD;
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  a_done_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |=> (state_q == ST_LOAD))
    else $error("controller did not return to loading after a result");

  a_last_starts_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD && start_i && frame_last_i) |=> (state_q == ST_THR_PULSE))
    else $error("last item did not start threshold setup");

  a_read_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_en |-> (busy_o && !cmd_o.load))
    else $error("store read while items are being accepted");

endmodule

// ===== hw/rtl/ppm_dp.sv =====
// Datapath: sample store, frame trackers, threshold unit and counting pass.
module ppm_dp
  import ppm_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ppm_sample_t sample_i,
  input  ppm_cfg_t    cfg_i,
  input  ppm_cmd_t    cmd_i,
  output ppm_status_t status_o,
  output ppm_result_t result_o
);

  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned IDX_W = $clog2(MAX_SAMPLES);

  logic [SAMPLE_W-1:0] mem [MAX_SAMPLES];

  // Frame trackers.
  logic        [CNT_W-1:0]    count_q;
  logic signed [SAMPLE_W-1:0] min_q, max_q;
  logic        [IDX_W-1:0]    peak_q;
  logic                       cross_seen_q;
  logic        [IDX_W-1:0]    cross_idx_q;

  // Thresholds.
  logic signed [THR_W-1:0] pulse_thr_q, low_thr_q, high_thr_q;
  logic        [FRAC_W-1:0] frac;
  logic        [SAMPLE_W-1:0] swing;
  logic        [SAMPLE_W:0] swing_full;
  logic        [FRAC_W+SAMPLE_W-1:0] product;
  logic signed [THR_W-1:0] base_s, thr_d;

  // Counting pass.
  logic        [IDX_W-1:0]    rd_addr_q;
  logic                       rd_valid_q;
  logic signed [SAMPLE_W-1:0] rd_data_q;
  logic signed [SAMPLE_W-1:0] prev_q;
  logic                       prev_in_band_q;
  logic                       has_prev_q;
  logic        [CNT_W-1:0]    pulse_cnt_q, rise_cnt_q, fall_cnt_q;
  logic signed [THR_W-1:0]    scaled;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;
  logic signed [SAMPLE_W-1:0] v;

  assign v      = sample_i.sample_value;
  assign wr_en  = cmd_i.load && (count_q < CNT_W'(MAX_SAMPLES));
  assign wr_idx = count_q[IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_idx] <= v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_data_q <= $signed(mem[rd_addr_q]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      min_q        <= '0;
      max_q        <= '0;
      peak_q       <= '0;
      cross_seen_q <= 1'b0;
      cross_idx_q  <= '0;
    end else if (cmd_i.finish) begin
      count_q      <= '0;
      min_q        <= '0;
      max_q        <= '0;
      peak_q       <= '0;
      cross_seen_q <= 1'b0;
      cross_idx_q  <= '0;
    end else if (wr_en) begin
      // The first item of a frame replaces both extremes.
      if (count_q == '0) begin
        min_q  <= v;
        max_q  <= v;
        peak_q <= '0;
      end else begin
        if (v < min_q) begin
          min_q <= v;
        end
        if (v > max_q) begin
          max_q  <= v;
          peak_q <= wr_idx;
        end
      end
      if (!cross_seen_q && (v >= cfg_i.target_level)) begin
        cross_seen_q <= 1'b1;
        cross_idx_q  <= wr_idx;
      end
      count_q <= count_q + CNT_W'(1);
    end
  end

  always_comb begin
    case (cmd_i.thr_sel)
      THR_PULSE: frac = cfg_i.pulse_frac;
      THR_LOW:   frac = cfg_i.edge_low_frac;
      THR_HIGH:  frac = cfg_i.edge_high_frac;
      default:   frac = cfg_i.pulse_frac;
    endcase
    // max is never below min, so the swing fits unsigned in SAMPLE_W bits.
    swing_full = (SAMPLE_W+1)'(max_q) - (SAMPLE_W+1)'(min_q);
    swing      = swing_full[SAMPLE_W-1:0];
    product    = (FRAC_W+SAMPLE_W)'(frac) * (FRAC_W+SAMPLE_W)'(swing);
    base_s     = THR_W'($signed({min_q, {FRAC_W{1'b0}}}));
    thr_d      = base_s + $signed({1'b0, product});
    scaled     = THR_W'($signed({rd_data_q, {FRAC_W{1'b0}}}));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.thr_en) begin
      case (cmd_i.thr_sel)
        THR_PULSE: pulse_thr_q <= thr_d;
        THR_LOW:   low_thr_q   <= thr_d;
        THR_HIGH:  high_thr_q  <= thr_d;
        default:   pulse_thr_q <= thr_d;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_valid_q) begin
      prev_q         <= rd_data_q;
      prev_in_band_q <= (scaled > low_thr_q) && (scaled < high_thr_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_addr_q   <= '0;
      rd_valid_q  <= 1'b0;
      has_prev_q  <= 1'b0;
      pulse_cnt_q <= '0;
      rise_cnt_q  <= '0;
      fall_cnt_q  <= '0;
    end else begin
      rd_valid_q <= cmd_i.rd_en;
      if (cmd_i.pass_init) begin
        rd_addr_q   <= '0;
        has_prev_q  <= 1'b0;
        pulse_cnt_q <= '0;
        rise_cnt_q  <= '0;
        fall_cnt_q  <= '0;
      end else begin
        if (cmd_i.rd_en) begin
          rd_addr_q <= rd_addr_q + IDX_W'(1);
        end
        if (rd_valid_q) begin
          has_prev_q <= 1'b1;
          if (scaled > pulse_thr_q) begin
            pulse_cnt_q <= pulse_cnt_q + CNT_W'(1);
          end
          // The previous item is judged now that its successor is known.
          if (has_prev_q && prev_in_band_q) begin
            if (rd_data_q > prev_q) begin
              rise_cnt_q <= rise_cnt_q + CNT_W'(1);
            end else if (rd_data_q < prev_q) begin
              fall_cnt_q <= fall_cnt_q + CNT_W'(1);
            end
          end
        end
      end
    end
  end

  assign status_o.rd_last = ((CNT_W'(rd_addr_q) + CNT_W'(1)) == count_q);

  always_comb begin
    result_o.pulse_width_count = COUNT_W'(pulse_cnt_q);
    result_o.rise_count        = COUNT_W'(rise_cnt_q);
    result_o.fall_count        = COUNT_W'(fall_cnt_q);
    result_o.level_found       = cross_seen_q;
    result_o.level_cross_index = cross_seen_q ? INDEX_W'(cross_idx_q) : '0;
    result_o.peak_index        = INDEX_W'(peak_q);
    result_o.min_value         = min_q;
    result_o.max_value         = max_q;
  end

  a_read_follows_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_valid_q |-> $past(cmd_i.rd_en))
    else $error("read data marked valid without a read");

  a_extremes_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) |-> (min_q <= max_q))
    else $error("frame minimum above maximum");

  // While the pass runs, the counters cover only the items read before the current one.
  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= CNT_W'(MAX_SAMPLES))
    && (!rd_valid_q || ((pulse_cnt_q < count_q)
                        && ((rise_cnt_q + fall_cnt_q) < count_q))))
    else $error("pass count exceeds the stored frame");

endmodule
